// ===== hw/rtl/mhrs_pkg.sv =====
package mhrs_pkg;

   localparam int ADDR_BITS_DEF = 8;
   localparam int MAX_READ_DEF  = 63;

   localparam logic [7:0] FC_READ      = 8'h03;
   localparam logic [7:0] FC_WRITE     = 8'h06;
   localparam logic [7:0] EXC_FUNCTION = 8'h01;
   localparam logic [7:0] EXC_ADDRESS  = 8'h02;
   localparam logic [7:0] EXC_FLAG     = 8'h80;

   localparam logic [15:0] MBAP_LEN_REQ = 16'd6;
   localparam logic [15:0] LEN_EXC      = 16'd3;
   localparam logic [15:0] LEN_ECHO     = 16'd6;
   localparam logic [7:0]  STATION_RST  = 8'd1;

   localparam logic OP_REQUEST = 1'b0;
   localparam logic OP_PRELOAD = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ = 2'd0,
      KIND_EXC  = 2'd1,
      KIND_ECHO = 2'd2,
      KIND_DATA = 2'd3
   } kind_type;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_CHECK  = 6'b000100,
      ST_DECIDE = 6'b001000,
      ST_EMIT   = 6'b010000,
      ST_ECHO   = 6'b100000
   } state_type;

endpackage

// ===== hw/rtl/modbus_holding_register_server_core.sv =====
// Every response output is registered; the receiver cannot stall. Preload and dropped requests
// leave the core idle and header-level exceptions are answered from idle; a write passes through
// ST_ECHO. A read of q registers probes one register per cycle, then gives its header: a failed
// probe ends the read there, else one store read is primed with no word out and q data words
// follow back to back. Reset is synchronous; afterwards all 2**ADDR_BITS store entries are swept
// clear with busy high (csr writes taken meanwhile).
module modbus_holding_register_server_core import mhrs_pkg::*; #(
   parameter int ADDR_BITS = ADDR_BITS_DEF,
   parameter int MAX_READ  = MAX_READ_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_op,
   input  logic [15:0] req_trans_id,
   input  logic [15:0] req_proto_id,
   input  logic [15:0] req_length,
   input  logic [7:0]  req_unit_id,
   input  logic [7:0]  req_func,
   input  logic [15:0] req_address,
   input  logic [15:0] req_operand,
   output logic        rsp_valid,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_trans_id,
   output logic        rsp_proto_id,
   output logic [15:0] rsp_length_out,
   output logic [7:0]  rsp_unit_id_out,
   output logic [7:0]  rsp_function_out,
   output logic [7:0]  rsp_count_or_code,
   output logic [15:0] rsp_data_word,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam int DEPTH = 1 << ADDR_BITS;
   localparam int CNT_W = $clog2(MAX_READ + 1);

   // store entry: {present, value}
   logic [16:0] store_mem [DEPTH];
   logic [16:0] mem_q_ff;
   logic        mem_we;
   logic [ADDR_BITS-1:0] mem_waddr;
   logic [16:0] mem_wdata;

   state_type state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [7:0]  station_ff, station_in;
   logic [15:0] cursor_ff, cursor_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] qty_ff, qty_in;
   logic        pend_ff, pend_in;
   logic        pend_win_ff, pend_win_in;
   logic        pend_last_ff, pend_last_in;
   logic        fail_ff, fail_in;
   logic [15:0] tid_ff, tid_in;
   logic [7:0]  unit_ff, unit_in;
   logic [7:0]  fn_ff, fn_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] voq_ff, voq_in;

   logic        rvalid_ff, rvalid_in;
   kind_type    rkind_ff, rkind_in;
   logic [15:0] rtid_ff, rtid_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [7:0]  runit_ff, runit_in;
   logic [7:0]  rfn_ff, rfn_in;
   logic [7:0]  rcc_ff, rcc_in;
   logic [15:0] rdata_ff, rdata_in;
   logic        rlast_ff, rlast_in;

   logic accept, hdr_ok, req_in_win, qty_ok, cur_in_win;

   assign accept     = start && !busy;
   assign hdr_ok     = (req_proto_id == 16'd0) && (req_length == MBAP_LEN_REQ) &&
                       (req_unit_id == station_ff);
   assign req_in_win = (req_address >> ADDR_BITS) == 16'd0;
   assign cur_in_win = (cursor_ff >> ADDR_BITS) == 16'd0;
   assign qty_ok     = (req_operand != 16'd0) &&
                       (req_operand <= 16'(MAX_READ));

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      station_in   = station_ff;
      cursor_in    = cursor_ff;
      cnt_in       = cnt_ff;
      qty_in       = qty_ff;
      pend_in      = 1'b0;
      pend_win_in  = pend_win_ff;
      pend_last_in = pend_last_ff;
      fail_in      = fail_ff;
      tid_in       = tid_ff;
      unit_in      = unit_ff;
      fn_in        = fn_ff;
      addr_in      = addr_ff;
      voq_in       = voq_ff;
      mem_we       = 1'b0;
      mem_waddr    = req_address[ADDR_BITS-1:0];
      mem_wdata    = {1'b1, req_operand};
      rvalid_in    = 1'b0;
      rkind_in     = KIND_DATA;
      rtid_in      = 16'd0;
      rlen_in      = 16'd0;
      runit_in     = 8'd0;
      rfn_in       = 8'd0;
      rcc_in       = 8'd0;
      rdata_in     = 16'd0;
      rlast_in     = 1'b0;

      if (csr_valid && csr_ready) begin
         station_in = csr_data;
      end

      case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + ADDR_BITS'(1);
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               tid_in  = req_trans_id;
               unit_in = req_unit_id;
               fn_in   = req_func;
               addr_in = req_address;
               voq_in  = req_operand;
               if (req_op == OP_PRELOAD) begin
                  mem_we = req_in_win;
               end else if (hdr_ok) begin
                  if (req_func == FC_READ) begin
                     if (qty_ok) begin
                        cursor_in = req_address;
                        cnt_in    = CNT_W'(req_operand);
                        qty_in    = CNT_W'(req_operand);
                        fail_in   = 1'b0;
                        state_in  = ST_CHECK;
                     end else begin
                        rvalid_in = 1'b1;
                        rkind_in  = KIND_EXC;
                        rtid_in   = req_trans_id;
                        rlen_in   = LEN_EXC;
                        runit_in  = req_unit_id;
                        rfn_in    = req_func | EXC_FLAG;
                        rcc_in    = EXC_ADDRESS;
                        rlast_in  = 1'b1;
                     end
                  end else if (req_func == FC_WRITE) begin
                     mem_we    = req_in_win;
                     rvalid_in = 1'b1;
                     rkind_in  = KIND_ECHO;
                     rtid_in   = req_trans_id;
                     rlen_in   = LEN_ECHO;
                     runit_in  = req_unit_id;
                     rfn_in    = req_func;
                     rdata_in  = req_address;
                     state_in  = ST_ECHO;
                  end else begin
                     rvalid_in = 1'b1;
                     rkind_in  = KIND_EXC;
                     rtid_in   = req_trans_id;
                     rlen_in   = LEN_EXC;
                     runit_in  = req_unit_id;
                     rfn_in    = req_func | EXC_FLAG;
                     rcc_in    = EXC_FUNCTION;
                     rlast_in  = 1'b1;
                  end
               end
            end
         end
         ST_CHECK: begin
            // probe issued last cycle is judged now against the registered read
            if (pend_ff && !(mem_q_ff[16] && pend_win_ff)) begin
               fail_in = 1'b1;
            end
            if (cnt_ff != '0) begin
               pend_in     = 1'b1;
               pend_win_in = cur_in_win;
               cursor_in   = cursor_ff + 16'd1;
               cnt_in      = cnt_ff - CNT_W'(1);
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rvalid_in = 1'b1;
            rtid_in   = tid_ff;
            runit_in  = unit_ff;
            if (fail_ff) begin
               rkind_in = KIND_EXC;
               rlen_in  = LEN_EXC;
               rfn_in   = fn_ff | EXC_FLAG;
               rcc_in   = EXC_ADDRESS;
               rlast_in = 1'b1;
               state_in = ST_IDLE;
            end else begin
               rkind_in  = KIND_READ;
               rlen_in   = LEN_EXC + 16'({qty_ff, 1'b0});
               rfn_in    = fn_ff;
               rcc_in    = 8'({qty_ff, 1'b0});
               cursor_in = addr_ff;
               cnt_in    = qty_ff;
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (cnt_ff != '0) begin
               pend_in      = 1'b1;
               pend_last_in = (cnt_ff == CNT_W'(1));
               cursor_in    = cursor_ff + 16'd1;
               cnt_in       = cnt_ff - CNT_W'(1);
            end
            if (pend_ff) begin
               rvalid_in = 1'b1;
               rkind_in  = KIND_DATA;
               rdata_in  = mem_q_ff[15:0];
               rlast_in  = pend_last_ff;
               if (cnt_ff == '0) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ECHO: begin
            rvalid_in = 1'b1;
            rkind_in  = KIND_DATA;
            rdata_in  = voq_ff;
            rlast_in  = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         station_ff <= STATION_RST;
         pend_ff    <= 1'b0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         station_ff <= station_in;
         pend_ff    <= pend_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cursor_ff    <= cursor_in;
      cnt_ff       <= cnt_in;
      qty_ff       <= qty_in;
      pend_win_ff  <= pend_win_in;
      pend_last_ff <= pend_last_in;
      fail_ff      <= fail_in;
      tid_ff       <= tid_in;
      unit_ff      <= unit_in;
      fn_ff        <= fn_in;
      addr_ff      <= addr_in;
      voq_ff       <= voq_in;
      rkind_ff     <= rkind_in;
      rtid_ff      <= rtid_in;
      rlen_ff      <= rlen_in;
      runit_ff     <= runit_in;
      rfn_ff       <= rfn_in;
      rcc_ff       <= rcc_in;
      rdata_ff     <= rdata_in;
      rlast_ff     <= rlast_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= store_mem[cursor_ff[ADDR_BITS-1:0]];
   end

   assign busy              = (state_ff != ST_IDLE);
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rvalid_ff;
   assign rsp_kind          = rkind_ff;
   assign rsp_trans_id      = rtid_ff;
   assign rsp_proto_id      = 1'b0;
   assign rsp_length_out    = rlen_ff;
   assign rsp_unit_id_out   = runit_ff;
   assign rsp_function_out  = rfn_ff;
   assign rsp_count_or_code = rcc_ff;
   assign rsp_data_word     = rdata_ff;
   assign rsp_last          = rlast_ff;

endmodule

// ===== hw/rtl/mhrs_checker.sv =====
module mhrs_checker import mhrs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_op,
   input logic        rsp_valid,
   input logic [1:0]  rsp_kind,
   input logic [15:0] rsp_length_out,
   input logic [7:0]  rsp_function_out,
   input logic [7:0]  rsp_count_or_code,
   input logic        rsp_last
);

   // a preload transfer never produces a response
   a_preload_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_op == OP_PRELOAD) |=> !rsp_valid)
      else $error("response after preload");

   a_echo_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ECHO && !rsp_last) |=>
      (rsp_valid && rsp_kind == KIND_DATA && rsp_last))
      else $error("echo header not followed by final value word");

   a_exc_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_EXC) |-> (rsp_last && rsp_function_out[7]))
      else $error("malformed exception");

   // data words of one read come back to back
   a_data_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DATA && !rsp_last) |=>
      (rsp_valid && rsp_kind == KIND_DATA))
      else $error("gap in read data burst");

   a_read_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_READ) |->
      (rsp_length_out == LEN_EXC + 16'(rsp_count_or_code) && !rsp_last))
      else $error("read header length mismatch");

endmodule

bind modbus_holding_register_server_core mhrs_checker u_mhrs_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_op            (req_op),
   .rsp_valid         (rsp_valid),
   .rsp_kind          (rsp_kind),
   .rsp_length_out    (rsp_length_out),
   .rsp_function_out  (rsp_function_out),
   .rsp_count_or_code (rsp_count_or_code),
   .rsp_last          (rsp_last)
);
